/* hdl/clr_pkg.sv */
`default_nettype none

package clr_pkg;

  localparam int SAMPLE_W = 24;
  localparam int RATIO_W = 29;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 29'h100_0000;

  // Upper bound on interpolated outputs produced by one source sample.
  localparam int MAX_UPSAMPLE = 16;
  localparam int CNT_W = $clog2(MAX_UPSAMPLE + 1);

  // Datapath operations issued by the controller, at most one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_PROD,
    OP_EXPAND,
    OP_SCALE,
    OP_COEF,
    OP_WEIGHT,
    OP_SUM,
    OP_EMIT,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic below;
    logic next_below;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/clr_dp.sv */
`default_nettype none

module clr_dp import clr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [RATIO_W-1:0]         rate_ratio,
  input  logic signed [SAMPLE_W-1:0] source_sample,
  input  dp_cmd_t                    cmd,
  output dp_status_t                 status,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       last_of_run
);

  localparam int POS_W = 34;
  localparam int NUM_W = 52;
  localparam int COEF_W = 26;
  localparam int PROD_W = 50;
  localparam logic signed [POS_W-1:0] NEG_ONE = -34'sd16777216;
  localparam logic signed [POS_W-1:0] NEG_TWO = -34'sd33554432;
  localparam logic [NUM_W-1:0] HALF_SIX = 52'd50331648;
  localparam logic [NUM_W-1:0] HALF_TWO = 52'd16777216;
  localparam logic [NUM_W-1:0] HALF_OUT = 52'd8388608;
  // ceil(2^27 / 6): exact floor division by six for operands below 2^24.
  localparam logic [24:0] RECIP6 = 25'd22369622;

  function automatic logic [NUM_W-1:0] mag(input logic signed [NUM_W-1:0] v);
    logic [NUM_W-1:0] r;
    r = v[NUM_W-1] ? $unsigned(-v) : $unsigned(v);
    return r;
  endfunction

  // Control state.
  logic signed [POS_W-1:0]    pos;
  logic [RATIO_W-1:0]         ratio;
  logic signed [SAMPLE_W-1:0] hist [4];

  // Working registers.
  logic signed [31:0]         p_ad;
  logic signed [33:0]         q_b;
  logic signed [33:0]         r_c;
  logic signed [NUM_W-1:0]    num_a, num_b, num_c, num_d;
  logic [48:0]                y_a, y_d;
  logic                       neg_a, neg_d;
  logic signed [COEF_W-1:0]   coef_a, coef_b, coef_c, coef_d;
  logic signed [PROD_W-1:0]   prod_a, prod_b, prod_c, prod_d;
  logic signed [NUM_W-1:0]    acc;

  // Combinational terms.
  logic signed [POS_W-1:0]    pos_adv;
  logic signed [POS_W-1:0]    pos_fin;
  logic signed [17:0]         s0, s1, s2, s3;
  logic signed [35:0]         m_ad, m_b, m_c;
  logic signed [49:0]         e_a, e_d;
  logic signed [51:0]         e_b, e_c;
  logic [NUM_W-1:0]           rnd_a, rnd_b, rnd_c, rnd_d;
  logic [48:0]                y_a_w, y_d_w;
  logic [24:0]                qb, qc;
  logic [21:0]                qa, qd;
  logic signed [PROD_W-1:0]   w_a, w_b, w_c, w_d;
  logic [NUM_W-1:0]           rnd_acc;
  logic [27:0]                r_out;
  logic [27:0]                r_neg;
  logic [SAMPLE_W-1:0]        res;

  assign pos_adv = pos + $signed({{(POS_W - RATIO_W){1'b0}}, ratio});
  assign pos_fin = (pos < NEG_ONE) ? NEG_TWO : pos + NEG_ONE;
  assign status.below = pos < NEG_ONE;
  assign status.next_below = pos_adv < NEG_ONE;

  // The fraction t of the way from h1 to h2 is pos[23:8] in every case.
  assign s0 = $signed({2'b00, pos[23:8]});
  assign s1 = s0 - 18'sd65536;
  assign s2 = s0 - 18'sd131072;
  assign s3 = s0 + 18'sd65536;

  assign m_ad = s0 * s1;
  assign m_b = s3 * s1;
  assign m_c = s3 * s0;

  assign e_a = p_ad * s2;
  assign e_b = q_b * s2;
  assign e_c = r_c * s2;
  assign e_d = p_ad * s3;

  assign rnd_a = mag(num_a) + HALF_SIX;
  assign rnd_d = mag(num_d) + HALF_SIX;
  assign rnd_b = mag(num_b) + HALF_TWO;
  assign rnd_c = mag(num_c) + HALF_TWO;
  assign y_a_w = rnd_a[47:24] * RECIP6;
  assign y_d_w = rnd_d[47:24] * RECIP6;
  assign qb = rnd_b[49:25];
  assign qc = rnd_c[49:25];
  assign qa = y_a[48:27];
  assign qd = y_d[48:27];

  assign w_a = coef_a * hist[0];
  assign w_b = coef_b * hist[1];
  assign w_c = coef_c * hist[2];
  assign w_d = coef_d * hist[3];

  assign rnd_acc = mag(acc) + HALF_OUT;
  assign r_out = rnd_acc[51:24];
  assign r_neg = 28'd0 - r_out;

  always_comb begin
    if (!acc[NUM_W-1]) begin
      res = (r_out > 28'd8388607) ? 24'h7F_FFFF : r_out[SAMPLE_W-1:0];
    end else begin
      res = (r_out > 28'd8388608) ? 24'h80_0000 : r_neg[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ratio <= RATIO_RESET;
      for (int i = 0; i < 4; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        ratio <= rate_ratio;
      end
      unique case (cmd.op)
        OP_START: begin
          hist[0] <= hist[1];
          hist[1] <= hist[2];
          hist[2] <= hist[3];
          hist[3] <= source_sample;
        end
        OP_EMIT:   pos <= pos_adv;
        // Stored as a 32-bit two's complement position.
        OP_FINISH: pos <= {{(POS_W - 32){pos_fin[31]}}, pos_fin[31:0]};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PROD: begin
        p_ad <= m_ad[31:0];
        q_b <= m_b[33:0];
        r_c <= m_c[33:0];
      end
      OP_EXPAND: begin
        num_a <= -$signed({{2{e_a[49]}}, e_a});
        num_b <= e_b;
        num_c <= -e_c;
        num_d <= $signed({{2{e_d[49]}}, e_d});
      end
      OP_SCALE: begin
        y_a <= y_a_w;
        y_d <= y_d_w;
        neg_a <= num_a[NUM_W-1];
        neg_d <= num_d[NUM_W-1];
        coef_b <= num_b[NUM_W-1] ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
        coef_c <= num_c[NUM_W-1] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
      end
      OP_COEF: begin
        coef_a <= neg_a ? -$signed({4'b0, qa}) : $signed({4'b0, qa});
        coef_d <= neg_d ? -$signed({4'b0, qd}) : $signed({4'b0, qd});
      end
      OP_WEIGHT: begin
        prod_a <= w_a;
        prod_b <= w_b;
        prod_c <= w_c;
        prod_d <= w_d;
      end
      OP_SUM: begin
        acc <= $signed({{2{prod_a[PROD_W-1]}}, prod_a})
             + $signed({{2{prod_b[PROD_W-1]}}, prod_b})
             + $signed({{2{prod_c[PROD_W-1]}}, prod_c})
             + $signed({{2{prod_d[PROD_W-1]}}, prod_d});
      end
      OP_EMIT: begin
        out_sample <= $signed(res);
        last_of_run <= cmd.last;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/clr_ctrl.sv */
`default_nettype none

module clr_ctrl import clr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PROD,
    S_EXPAND,
    S_SCALE,
    S_COEF,
    S_WEIGHT,
    S_SUM,
    S_EMIT,
    S_FINISH
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             slot_free;
  logic             more;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    slot_free = !out_valid || out_ready;
    // Another output follows if the advanced position is still in the
    // window and the per-input output limit has not been reached.
    more = status.next_below && (cnt != CNT_W'(MAX_UPSAMPLE - 1));
    state_next = state;
    cnt_next = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd.op = OP_NONE;
    cmd.last = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_START;
          cnt_next = '0;
          state_next = S_CHECK;
        end
      end
      S_CHECK:  state_next = status.below ? S_PROD : S_FINISH;
      S_PROD: begin
        cmd.op = OP_PROD;
        state_next = S_EXPAND;
      end
      S_EXPAND: begin
        cmd.op = OP_EXPAND;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.op = OP_SCALE;
        state_next = S_COEF;
      end
      S_COEF: begin
        cmd.op = OP_COEF;
        state_next = S_WEIGHT;
      end
      S_WEIGHT: begin
        cmd.op = OP_WEIGHT;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op = OP_SUM;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.op = OP_EMIT;
          cmd.last = !more;
          out_valid_next = 1'b1;
          cnt_next = cnt + CNT_W'(1);
          state_next = more ? S_PROD : S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.op = OP_FINISH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_UPSAMPLE))
    else $error("output count exceeded the per-input limit");

  a_limit_is_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT && cnt == CNT_W'(MAX_UPSAMPLE - 1)) |-> cmd.last)
    else $error("output at the per-input limit not flagged as last");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == OP_EMIT))
    else $error("output valid rose without an emit");

  a_check_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (cnt == '0))
    else $error("output count not cleared at start of an input");

endmodule

`default_nettype wire

/* hdl/cubic_lagrange_resampler.sv */
// Channel   Handshake              Payload
// input     in_valid / in_ready    source_sample
// output    out_valid / out_ready  out_sample, last_of_run
// config    cfg_write              rate_ratio
//
// One source sample causes from 0 to 16 outputs. Each output walks one shared
// four-lane datapath through seven steps: products, expansion, scaling,
// coefficient rounding, weighting, sum and emit. in_ready is high only
// between samples; a stalled output register holds the next emit step and
// nothing else. Reset clears the sample history and the position and sets
// the ratio to 1.0.

`default_nettype none

module cubic_lagrange_resampler import clr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] source_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       last_of_run,
  input  logic                       cfg_write,
  input  logic [RATIO_W-1:0]         rate_ratio
);

  dp_cmd_t    cmd;
  dp_status_t status;

  clr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  clr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .rate_ratio    (rate_ratio),
    .source_sample (source_sample),
    .cmd           (cmd),
    .status        (status),
    .out_sample    (out_sample),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire

/* test/clr_checker.sv */
`timescale 1ns / 1ps

module clr_checker import clr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] source_sample,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       last_of_run,
  input  logic                       cfg_write,
  input  logic [RATIO_W-1:0]         rate_ratio,
  output int                         fail_count,
  output int                         pending
);

  localparam longint ONE_POS = 64'sd1 << 24;
  localparam longint SAT_HI = (64'sd1 << (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO = -(64'sd1 << (SAMPLE_W - 1));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } resampled_t;

  resampled_t                 resampled_q[$];
  logic signed [SAMPLE_W-1:0] history[4];
  logic signed [31:0]         position;
  logic [RATIO_W-1:0]         ratio;

  // Division rounded to nearest with ties away from zero; the divisor is positive.
  function automatic longint round_near(input longint num, input longint den);
    if (num < 0) return -((-num + den / 2) / den);
    return (num + den / 2) / den;
  endfunction

  // Cubic Lagrange value at fraction t/2^16 between history[1] and history[2].
  function automatic logic signed [SAMPLE_W-1:0] lagrange_point(input longint t);
    longint u = 65536;
    longint acc;
    longint r;
    acc = round_near(-(t * (t - u) * (t - 2 * u)), 6 * ONE_POS) * history[0]
        + round_near((t + u) * (t - u) * (t - 2 * u), 2 * ONE_POS) * history[1]
        + round_near(-((t + u) * t * (t - 2 * u)), 2 * ONE_POS) * history[2]
        + round_near((t + u) * t * (t - u), 6 * ONE_POS) * history[3];
    r = round_near(acc, ONE_POS);
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    resampled_t due;
    resampled_t held;
    logic       have_held;
    longint     pos;
    longint     t;
    int         count;
    if (rst) begin
      for (int i = 0; i < 4; i++) history[i] = '0;
      position = '0;
      ratio = RATIO_RESET;
      resampled_q.delete();
    end else begin
      if (cfg_write) ratio = rate_ratio;

      // An output transaction at this edge always belongs to an earlier input.
      if (out_valid && out_ready) begin
        if (resampled_q.size() == 0) begin
          $error("out_sample: expected no transaction, got %0d", out_sample);
          fail_count++;
        end else begin
          due = resampled_q.pop_front();
          if (due.sample !== out_sample) begin
            $error("out_sample: expected %0d, got %0d", $signed(due.sample), out_sample);
            fail_count++;
          end
          if (due.last !== last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", due.last, last_of_run);
            fail_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        pos = longint'(position);
        history[0] = history[1];
        history[1] = history[2];
        history[2] = history[3];
        history[3] = source_sample;
        count = 0;
        have_held = 1'b0;
        while (pos < -ONE_POS && count < MAX_UPSAMPLE) begin
          if (have_held) resampled_q.push_back(held);
          t = ((pos + 2 * ONE_POS) & 64'hFF_FFFF) >> 8;
          held.sample = lagrange_point(t);
          held.last = 1'b0;
          have_held = 1'b1;
          pos += longint'(ratio);
          count++;
        end
        if (have_held) begin
          held.last = 1'b1;
          resampled_q.push_back(held);
        end
        // Positions still pending after the output cap are dropped.
        if (pos < -ONE_POS) pos = -ONE_POS;
        pos -= ONE_POS;
        position = pos[31:0];
      end
    end
    pending <= resampled_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

/* test/tb_cubic_lagrange_resampler.sv */
`timescale 1ns / 1ps

module tb_cubic_lagrange_resampler;
  import clr_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int SEGMENTS = 5;
  localparam int SEGMENT_ITEMS = 42;
  localparam int STEADY_SEGMENT = 2;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [RATIO_W-1:0] RATIO_LOW = 29'h010_0000;
  localparam logic [RATIO_W-1:0] RATIO_HIGH = 29'h1000_0000;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] source_sample;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       last_of_run;
  logic                       cfg_write;
  logic [RATIO_W-1:0]         rate_ratio;
  logic                       steady;
  int                         fail_count;
  int                         pending;
  int                         idle_cycles = 0;

  cubic_lagrange_resampler dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .source_sample(source_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample(out_sample),
    .last_of_run(last_of_run),
    .cfg_write(cfg_write),
    .rate_ratio(rate_ratio)
  );

  clr_checker u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .source_sample(source_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample(out_sample),
    .last_of_run(last_of_run),
    .cfg_write(cfg_write),
    .rate_ratio(rate_ratio),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    source_sample <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the input off until every expected transaction has come out and the
  // block has had time to finish a sample that produces no output.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] value);
    settle();
    cfg_write <= 1'b1;
    rate_ratio <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_W'($urandom_range(255) - 128);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    source_sample = '0;
    cfg_write = 1'b0;
    rate_ratio = RATIO_RESET;
    steady = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // At the reset ratio of 1.0 the first two samples produce nothing and the
    // rest reproduce the history exactly.
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_W'(-1));

    // A zero ratio hits the output cap on every sample.
    write_ratio('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);

    // Full-scale alternation at a ratio of 1/16, the densest that stays within the output cap.
    write_ratio(RATIO_LOW);
    for (int i = 0; i < 4; i++) send_sample(i % 2 ? SAMPLE_MAX : SAMPLE_MIN);

    // Large ratios leave most samples without any output.
    write_ratio('1);
    for (int i = 0; i < 4; i++) send_sample(random_sample());
    write_ratio(RATIO_HIGH);
    for (int i = 0; i < 4; i++) send_sample(i % 2 ? SAMPLE_MIN : SAMPLE_MAX);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: write_ratio(RATIO_W'($urandom_range(32'h0100_0000, RATIO_LOW)));
        1: write_ratio(RATIO_W'($urandom_range(32'h0300_0000, 32'h0100_0000)));
        2: write_ratio(RATIO_W'($urandom_range(32'h0200_0000, RATIO_LOW)));
        3: write_ratio(RATIO_W'($urandom_range(RATIO_HIGH, RATIO_LOW)));
        default: write_ratio(RATIO_W'($urandom_range(32'h0180_0000, 32'h0080_0000)));
      endcase
      steady = (seg == STEADY_SEGMENT);
      for (int i = 0; i < SEGMENT_ITEMS; i++) send_sample(random_sample());
    end
    steady = 1'b0;

    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
